// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check sampled on the rising clock, idle during reset
`define CHECK_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// implication check: cause in one cycle, effect in the same cycle
`define CHECK_IMPLIES(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error(msg);
`endif

// ----- rtl/tce_pkg.sv -----
package tce_pkg;
   localparam int MAX_RANGES = 8;
   localparam int HOLD_DEPTH = 32;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int HL_W = $clog2(HOLD_DEPTH + 1);
   localparam int HA_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int RANGE_W = 64;

   localparam logic [31:0] LP_MAX = 32'hFFFF_FFFF;
   localparam logic [7:0] NL = 8'd10;
   localparam logic [7:0] DELIM_RESET = 8'd9;

   localparam logic [1:0] OP_DATA = 2'd0;
   localparam logic [1:0] OP_ADD = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STS_OK = 2'd0;
   localparam logic [1:0] STS_BAD = 2'd1;
   localparam logic [1:0] STS_FULL = 2'd2;
   localparam logic [1:0] STS_TRUNC = 2'd3;

   localparam logic [1:0] CSR_MODE = 2'd0;
   localparam logic [1:0] CSR_DELIM = 2'd1;
   localparam logic [1:0] CSR_SUPPRESS = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_SEL_RD, S_SEL_CHK, S_BYTE_HIT, S_F1_HIT, S_F1_DONE,
      S_F2, S_F3_HIT, S_NL_PUT, S_EOI_DONE, S_FL_RD, S_FL_PUT, S_STATUS_PUT,
      S_FINISH, S_AR_START, S_AR_SI_RD, S_AR_SI_CHK, S_AR_SJ_RD, S_AR_SJ_CHK,
      S_AR_DEC, S_AR_INS_RD, S_AR_INS_WR, S_AR_MV_RD, S_AR_MV_WR
   } state_type;

   typedef struct packed {
      logic put;
      logic close;
      logic [7:0] out_byte;
      logic has_byte;
      logic [1:0] status;
   } emit_cmd_type;

   typedef struct packed {
      logic ready;
      logic pend_valid;
   } emit_stat_type;
endpackage

// ----- rtl/text_column_extractor_core.sv -----
// Byte and field selector for line-oriented text.
// Input channel (req_): one transaction per item. op data streams a text byte,
// op add inserts a range into the sorted range table, op clear empties it.
// Result channel (rsp_): bytes selected from the line, delimiters, newlines and
// status-only results; rsp_last marks the final result of each input item.
// Configuration (csr_): mode, delimiter and suppress, written while idle.
// One input transaction is in flight at a time; req_stall is high from the
// cycle after acceptance until the item's last result is in the output stage.
// A plain data byte is tested against the range table through registered reads
// of its memory (up to two reads per selection test). A held field is flushed
// byte by byte from the hold memory. Adding a range scans the table entries
// and then shifts the entries that follow the insertion or merge point.
// Results pass through a holding stage and an output register, so a stalled
// receiver only blocks the block once both are full.
// Reset is synchronous: the range table and line state empty, registers go
// to position mode, tab delimiter, no suppress. No clearing pass is needed.
`include "assert_macros.svh"
module text_column_extractor_core import tce_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data_byte,
   input  logic req_end_of_input,
   input  logic [31:0] req_range_low,
   input  logic [31:0] req_range_high,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic rsp_has_byte,
   output logic [1:0] rsp_status,
   output logic rsp_last,
   input  logic csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);
   logic [IDX_W-1:0] rr_addr;
   logic [RANGE_W-1:0] rr_data;
   logic rw_en;
   logic [IDX_W-1:0] rw_addr;
   logic [RANGE_W-1:0] rw_data;
   logic [HA_W-1:0] hr_addr;
   logic [7:0] hr_data;
   logic hw_en;
   logic [HA_W-1:0] hw_addr;
   logic [7:0] hw_data;
   emit_cmd_type cmd;
   emit_stat_type stat;
   logic [CNT_W-1:0] range_count;

   tce_ram #(.WIDTH(RANGE_W), .DEPTH(MAX_RANGES)) u_range_ram (
      .clock(clock), .wr_en(rw_en), .wr_addr(rw_addr), .wr_data(rw_data),
      .rd_addr(rr_addr), .rd_data(rr_data)
   );

   tce_ram #(.WIDTH(8), .DEPTH(HOLD_DEPTH)) u_hold_ram (
      .clock(clock), .wr_en(hw_en), .wr_addr(hw_addr), .wr_data(hw_data),
      .rd_addr(hr_addr), .rd_data(hr_data)
   );

   tce_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_data_byte(req_data_byte), .req_end_of_input(req_end_of_input),
      .req_range_low(req_range_low), .req_range_high(req_range_high),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .rr_addr(rr_addr), .rr_data(rr_data),
      .rw_en(rw_en), .rw_addr(rw_addr), .rw_data(rw_data),
      .hr_addr(hr_addr), .hr_data(hr_data),
      .hw_en(hw_en), .hw_addr(hw_addr), .hw_data(hw_data),
      .cmd(cmd), .stat(stat), .range_count(range_count)
   );

   tce_emit u_emit (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte), .rsp_has_byte(rsp_has_byte),
      .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   // an idle block has handed every result of the last item to the output stage
   `CHECK_IMPLIES(a_idle_drained, clock, reset, !req_stall, !stat.pend_valid, "result held while idle")
   `CHECK_HOLDS(a_count_bound, clock, reset, range_count <= CNT_W'(MAX_RANGES), "range table overfilled")
   // a new transaction cannot be accepted while a result is being handed over
   `CHECK_IMPLIES(a_no_put_idle, clock, reset, !req_stall, !cmd.put, "result issued while idle")
endmodule

// ----- rtl/tce_ram.sv -----
module tce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/tce_emit.sv -----
module tce_emit import tce_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  emit_cmd_type cmd,
   output emit_stat_type stat,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic rsp_has_byte,
   output logic [1:0] rsp_status,
   output logic rsp_last
);
   logic pend_valid_ff, pend_valid_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic pend_has_ff, pend_has_in;
   logic [1:0] pend_status_ff, pend_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic out_has_ff, out_has_in;
   logic [1:0] out_status_ff, out_status_in;
   logic out_last_ff, out_last_in;
   logic out_free;
   logic ready;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ready = !pend_valid_ff || out_free;

   // one result is held back so the final one of a transaction can be marked
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_byte_in = pend_byte_ff;
      pend_has_in = pend_has_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_byte_in = out_byte_ff;
      out_has_in = out_has_ff;
      out_status_in = out_status_ff;
      out_last_in = out_last_ff;
      if (cmd.put && ready) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            out_byte_in = pend_byte_ff;
            out_has_in = pend_has_ff;
            out_status_in = pend_status_ff;
            out_last_in = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_byte_in = cmd.out_byte;
         pend_has_in = cmd.has_byte;
         pend_status_in = cmd.status;
      end else if (cmd.close && ready && pend_valid_ff) begin
         rsp_valid_in = 1'b1;
         out_byte_in = pend_byte_ff;
         out_has_in = pend_has_ff;
         out_status_in = pend_status_ff;
         out_last_in = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_byte_ff <= pend_byte_in;
      pend_has_ff <= pend_has_in;
      pend_status_ff <= pend_status_in;
      out_byte_ff <= out_byte_in;
      out_has_ff <= out_has_in;
      out_status_ff <= out_status_in;
      out_last_ff <= out_last_in;
   end

   assign stat.ready = ready;
   assign stat.pend_valid = pend_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_has_byte = out_has_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last = out_last_ff;
endmodule

// ----- rtl/tce_ctrl.sv -----
module tce_ctrl import tce_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data_byte,
   input  logic req_end_of_input,
   input  logic [31:0] req_range_low,
   input  logic [31:0] req_range_high,
   input  logic csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   output logic [IDX_W-1:0] rr_addr,
   input  logic [RANGE_W-1:0] rr_data,
   output logic rw_en,
   output logic [IDX_W-1:0] rw_addr,
   output logic [RANGE_W-1:0] rw_data,
   output logic [HA_W-1:0] hr_addr,
   input  logic [7:0] hr_data,
   output logic hw_en,
   output logic [HA_W-1:0] hw_addr,
   output logic [7:0] hw_data,
   output emit_cmd_type cmd,
   input  emit_stat_type stat,
   output logic [CNT_W-1:0] range_count
);
   state_type state_ff, state_in;
   state_type sel_ret_ff, sel_ret_in;
   state_type flush_ret_ff, flush_ret_in;
   logic mode_ff, mode_in;
   logic [7:0] delim_ff, delim_in;
   logic suppress_ff, suppress_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0] lp_ff, lp_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic any_ff, any_in;
   logic [HL_W-1:0] held_len_ff, held_len_in;
   logic ovf_ff, ovf_in;
   logic [1:0] op_ff, op_in;
   logic [7:0] byte_ff, byte_in;
   logic eoi_ff, eoi_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] hi_ff, hi_in;
   logic [32:0] sel_p_ff, sel_p_in;
   logic adv_ff, adv_in;
   logic hit_ff, hit_in;
   logic [HL_W-1:0] fk_ff, fk_in;
   logic [1:0] status_ff, status_in;
   logic [CNT_W-1:0] ri_ff, ri_in;
   logic [CNT_W-1:0] rj_ff, rj_in;
   logic [CNT_W-1:0] rk_ff, rk_in;
   logic [31:0] mstart_ff, mstart_in;
   logic [31:0] mend_ff, mend_in;

   logic [31:0] rd_start;
   logic [31:0] rd_end;
   logic [31:0] lp_pos;
   logic [31:0] lp_fld;
   logic [CNT_W-1:0] rk_dec;
   logic [CNT_W-1:0] mv_addr;
   logic [CNT_W-1:0] merged;
   logic is_nl;
   logic clear_line;

   assign rd_start = rr_data[63:32];
   assign rd_end = rr_data[31:0];
   assign lp_pos = (lp_ff == LP_MAX) ? lp_ff : lp_ff + 32'd1;
   assign lp_fld = (lp_ff < LP_MAX - 32'd1) ? lp_ff + 32'd1 : lp_ff;
   assign rk_dec = rk_ff - CNT_W'(1);
   assign mv_addr = CNT_W'(ri_ff + rk_ff - rj_ff + CNT_W'(1));
   assign merged = CNT_W'(rj_ff - ri_ff - CNT_W'(1));
   assign is_nl = (byte_ff == NL);

   assign req_stall = (state_ff != S_IDLE);
   assign hr_addr = fk_ff[HA_W-1:0];
   assign hw_addr = held_len_ff[HA_W-1:0];
   assign hw_data = byte_ff;
   assign range_count = count_ff;

   always_comb begin
      state_in = state_ff;
      sel_ret_in = sel_ret_ff;
      flush_ret_in = flush_ret_ff;
      mode_in = mode_ff;
      delim_in = delim_ff;
      suppress_in = suppress_ff;
      count_in = count_ff;
      lp_in = lp_ff;
      cur_in = cur_ff;
      any_in = any_ff;
      held_len_in = held_len_ff;
      ovf_in = ovf_ff;
      op_in = op_ff;
      byte_in = byte_ff;
      eoi_in = eoi_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      sel_p_in = sel_p_ff;
      adv_in = adv_ff;
      hit_in = hit_ff;
      fk_in = fk_ff;
      status_in = status_ff;
      ri_in = ri_ff;
      rj_in = rj_ff;
      rk_in = rk_ff;
      mstart_in = mstart_ff;
      mend_in = mend_ff;
      clear_line = 1'b0;
      cmd = '0;
      rr_addr = '0;
      rw_en = 1'b0;
      rw_addr = '0;
      rw_data = '0;
      hw_en = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE: mode_in = csr_write_data[0];
            CSR_DELIM: delim_in = csr_write_data;
            CSR_SUPPRESS: suppress_in = csr_write_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               byte_in = req_data_byte;
               eoi_in = req_end_of_input;
               lo_in = req_range_low;
               hi_in = req_range_high;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            adv_in = 1'b0;
            case (op_ff)
               OP_ADD: state_in = S_AR_START;
               OP_CLEAR: begin
                  count_in = '0;
                  status_in = STS_OK;
                  state_in = S_STATUS_PUT;
               end
               OP_DATA: begin
                  if (eoi_ff) begin
                     fk_in = '0;
                     flush_ret_in = S_EOI_DONE;
                     state_in = (mode_ff && lp_ff == 32'd0 && !suppress_ff) ?
                                S_FL_RD : S_EOI_DONE;
                  end else if (!mode_ff) begin
                     if (is_nl) begin
                        state_in = S_NL_PUT;
                     end else begin
                        lp_in = lp_pos;
                        sel_p_in = {1'b0, lp_pos};
                        sel_ret_in = S_BYTE_HIT;
                        state_in = S_SEL_RD;
                     end
                  end else if (byte_ff == delim_ff || (is_nl && lp_ff != 32'd0)) begin
                     if (lp_ff == 32'd0) begin
                        sel_p_in = 33'd1;
                        sel_ret_in = S_F1_HIT;
                        state_in = S_SEL_RD;
                     end else begin
                        state_in = S_F2;
                     end
                  end else if (is_nl) begin
                     if (!suppress_ff) begin
                        fk_in = '0;
                        flush_ret_in = S_NL_PUT;
                        state_in = S_FL_RD;
                     end else begin
                        clear_line = 1'b1;
                        state_in = S_FINISH;
                     end
                  end else if (lp_ff == 32'd0) begin
                     // first field is held until a delimiter, newline or end of input decides its fate
                     if (held_len_ff < HL_W'(HOLD_DEPTH)) begin
                        hw_en = 1'b1;
                        held_len_in = held_len_ff + HL_W'(1);
                        state_in = S_FINISH;
                     end else if (!ovf_ff) begin
                        ovf_in = 1'b1;
                        status_in = STS_TRUNC;
                        state_in = S_STATUS_PUT;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end else begin
                     sel_p_in = {1'b0, lp_ff} + 33'd1;
                     sel_ret_in = S_BYTE_HIT;
                     state_in = S_SEL_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SEL_RD: begin
            if (cur_ff < count_ff) begin
               rr_addr = cur_ff[IDX_W-1:0];
               state_in = S_SEL_CHK;
            end else begin
               hit_in = 1'b0;
               state_in = sel_ret_ff;
            end
         end
         S_SEL_CHK: begin
            // step past a finished range at most once per test
            if (!adv_ff && sel_p_ff > {1'b0, rd_end}) begin
               cur_in = cur_ff + CNT_W'(1);
               adv_in = 1'b1;
               state_in = S_SEL_RD;
            end else begin
               hit_in = (sel_p_ff >= {1'b0, rd_start}) && (sel_p_ff <= {1'b0, rd_end});
               state_in = sel_ret_ff;
            end
         end
         S_BYTE_HIT: begin
            if (!hit_ff) begin
               state_in = S_FINISH;
            end else if (stat.ready) begin
               cmd.put = 1'b1;
               cmd.out_byte = byte_ff;
               cmd.has_byte = 1'b1;
               cmd.status = STS_OK;
               state_in = S_FINISH;
            end
         end
         S_F1_HIT: begin
            if (hit_ff) begin
               any_in = 1'b1;
               fk_in = '0;
               flush_ret_in = S_F1_DONE;
               state_in = S_FL_RD;
            end else begin
               state_in = S_F1_DONE;
            end
         end
         S_F1_DONE: begin
            held_len_in = '0;
            state_in = S_F2;
         end
         S_F2: begin
            lp_in = lp_fld;
            adv_in = 1'b0;
            if (is_nl) begin
               state_in = S_NL_PUT;
            end else begin
               sel_p_in = {1'b0, lp_fld} + 33'd1;
               sel_ret_in = S_F3_HIT;
               state_in = S_SEL_RD;
            end
         end
         S_F3_HIT: begin
            if (!hit_ff) begin
               state_in = S_FINISH;
            end else if (!any_ff) begin
               any_in = 1'b1;
               state_in = S_FINISH;
            end else if (stat.ready) begin
               cmd.put = 1'b1;
               cmd.out_byte = delim_ff;
               cmd.has_byte = 1'b1;
               cmd.status = STS_OK;
               state_in = S_FINISH;
            end
         end
         S_NL_PUT: begin
            if (stat.ready) begin
               cmd.put = 1'b1;
               cmd.out_byte = NL;
               cmd.has_byte = 1'b1;
               cmd.status = STS_OK;
               clear_line = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_EOI_DONE: begin
            clear_line = 1'b1;
            state_in = S_FINISH;
         end
         S_FL_RD: begin
            state_in = (fk_ff < held_len_ff) ? S_FL_PUT : flush_ret_ff;
         end
         S_FL_PUT: begin
            if (stat.ready) begin
               cmd.put = 1'b1;
               cmd.out_byte = hr_data;
               cmd.has_byte = 1'b1;
               cmd.status = STS_OK;
               fk_in = fk_ff + HL_W'(1);
               state_in = S_FL_RD;
            end
         end
         S_STATUS_PUT: begin
            if (stat.ready) begin
               cmd.put = 1'b1;
               cmd.status = status_ff;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.close = 1'b1;
            if (stat.ready) begin
               state_in = S_IDLE;
            end
         end
         S_AR_START: begin
            if (lo_ff == 32'd0 || hi_ff == 32'd0 || lo_ff > hi_ff) begin
               status_in = STS_BAD;
               state_in = S_STATUS_PUT;
            end else begin
               ri_in = '0;
               state_in = S_AR_SI_RD;
            end
         end
         S_AR_SI_RD: begin
            if (ri_ff < count_ff) begin
               rr_addr = ri_ff[IDX_W-1:0];
               state_in = S_AR_SI_CHK;
            end else begin
               rj_in = ri_ff;
               state_in = S_AR_SJ_RD;
            end
         end
         S_AR_SI_CHK: begin
            if (lo_ff - 32'd1 > rd_end) begin
               ri_in = ri_ff + CNT_W'(1);
               state_in = S_AR_SI_RD;
            end else begin
               rj_in = ri_ff;
               state_in = S_AR_SJ_RD;
            end
         end
         S_AR_SJ_RD: begin
            if (rj_ff < count_ff) begin
               rr_addr = rj_ff[IDX_W-1:0];
               state_in = S_AR_SJ_CHK;
            end else begin
               state_in = S_AR_DEC;
            end
         end
         S_AR_SJ_CHK: begin
            // overlapping or touching entries fold into the new range
            if ({1'b0, hi_ff} + 33'd1 >= {1'b0, rd_start}) begin
               if (rj_ff == ri_ff) begin
                  mstart_in = rd_start;
               end
               mend_in = rd_end;
               rj_in = rj_ff + CNT_W'(1);
               state_in = S_AR_SJ_RD;
            end else begin
               state_in = S_AR_DEC;
            end
         end
         S_AR_DEC: begin
            if (rj_ff == ri_ff) begin
               if (count_ff >= CNT_W'(MAX_RANGES)) begin
                  status_in = STS_FULL;
                  state_in = S_STATUS_PUT;
               end else begin
                  rk_in = count_ff;
                  state_in = S_AR_INS_RD;
               end
            end else begin
               rw_en = 1'b1;
               rw_addr = ri_ff[IDX_W-1:0];
               rw_data = {(lo_ff < mstart_ff) ? lo_ff : mstart_ff,
                          (hi_ff > mend_ff) ? hi_ff : mend_ff};
               rk_in = rj_ff;
               state_in = S_AR_MV_RD;
            end
         end
         S_AR_INS_RD: begin
            if (rk_ff > ri_ff) begin
               rr_addr = rk_dec[IDX_W-1:0];
               state_in = S_AR_INS_WR;
            end else begin
               rw_en = 1'b1;
               rw_addr = ri_ff[IDX_W-1:0];
               rw_data = {lo_ff, hi_ff};
               count_in = count_ff + CNT_W'(1);
               status_in = STS_OK;
               state_in = S_STATUS_PUT;
            end
         end
         S_AR_INS_WR: begin
            rw_en = 1'b1;
            rw_addr = rk_ff[IDX_W-1:0];
            rw_data = rr_data;
            rk_in = rk_dec;
            state_in = S_AR_INS_RD;
         end
         S_AR_MV_RD: begin
            if (rk_ff < count_ff) begin
               rr_addr = rk_ff[IDX_W-1:0];
               state_in = S_AR_MV_WR;
            end else begin
               count_in = count_ff - merged;
               status_in = STS_OK;
               state_in = S_STATUS_PUT;
            end
         end
         S_AR_MV_WR: begin
            rw_en = 1'b1;
            rw_addr = mv_addr[IDX_W-1:0];
            rw_data = rr_data;
            rk_in = rk_ff + CNT_W'(1);
            state_in = S_AR_MV_RD;
         end
         default: state_in = S_IDLE;
      endcase

      if (clear_line) begin
         lp_in = '0;
         cur_in = '0;
         any_in = 1'b0;
         held_len_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= 1'b0;
         delim_ff <= DELIM_RESET;
         suppress_ff <= 1'b0;
         count_ff <= '0;
         lp_ff <= '0;
         cur_ff <= '0;
         any_ff <= 1'b0;
         held_len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         delim_ff <= delim_in;
         suppress_ff <= suppress_in;
         count_ff <= count_in;
         lp_ff <= lp_in;
         cur_ff <= cur_in;
         any_ff <= any_in;
         held_len_ff <= held_len_in;
         ovf_ff <= ovf_in;
      end
      sel_ret_ff <= sel_ret_in;
      flush_ret_ff <= flush_ret_in;
      op_ff <= op_in;
      byte_ff <= byte_in;
      eoi_ff <= eoi_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      sel_p_ff <= sel_p_in;
      adv_ff <= adv_in;
      hit_ff <= hit_in;
      fk_ff <= fk_in;
      status_ff <= status_in;
      ri_ff <= ri_in;
      rj_ff <= rj_in;
      rk_ff <= rk_in;
      mstart_ff <= mstart_in;
      mend_ff <= mend_in;
   end
endmodule
